// ===== rtl/atup_pkg.sv =====
// ----------------------------------------------------------------------------
// atup_pkg: shared types and constants
// Widths, character codes, queue sizing and the word formats passed between
// the front end, the queues and the back end of the parser.
// ----------------------------------------------------------------------------
package atup_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int OFFSET_BITS = 16;
    localparam int BASE_BITS   = 6;
    localparam int CHAR_BITS   = 8;

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_OFS = 8'd55;  // 'A' - 10
    localparam logic [CHAR_BITS-1:0] CH_LOWER_OFS = 8'd87;  // 'a' - 10

    localparam logic [BASE_BITS-1:0] BASE_OCT = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;

    // classified character
    typedef struct packed {
        logic                 start;
        logic                 is_space;
        logic                 is_sign;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_x;
        logic                 digit_ok;
        logic [BASE_BITS-1:0] digit;
    } class_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic                   overflowed;
        logic                   parsed_any;
        logic [OFFSET_BITS-1:0] end_offset;
    } result_t;

endpackage

// ===== rtl/atup_front.sv =====
// ----------------------------------------------------------------------------
// atup_front: character classifier
// Decodes one incoming character into space, sign, prefix and digit flags.
// ----------------------------------------------------------------------------
module atup_front
    import atup_pkg::*;
(
    input  logic [CHAR_BITS-1:0] char_in,
    input  logic                 start_flag,
    output class_t               cls
);

    logic                 is_dec;
    logic                 is_up;
    logic                 is_lo;
    logic [CHAR_BITS-1:0] dval;

    always_comb
    begin
        is_dec = (char_in >= CH_0)  && (char_in <= CH_9);
        is_up  = (char_in >= CH_UA) && (char_in <= CH_UZ);
        is_lo  = (char_in >= CH_LA) && (char_in <= CH_LZ);
        priority if (is_dec)
            dval = char_in - CH_0;
        else if (is_up)
            dval = char_in - CH_UPPER_OFS;
        else
            dval = char_in - CH_LOWER_OFS;

        cls.start    = start_flag;
        cls.is_space = (char_in == CH_SPACE) || (char_in == CH_NL) ||
                       (char_in == CH_CR) || (char_in == CH_TAB);
        cls.is_sign  = (char_in == CH_MINUS) || (char_in == CH_PLUS);
        cls.is_minus = (char_in == CH_MINUS);
        cls.is_zero  = (char_in == CH_0);
        cls.is_x     = (char_in == CH_UX) || (char_in == CH_LX);
        cls.digit_ok = is_dec || is_up || is_lo;
        cls.digit    = dval[BASE_BITS-1:0];
    end

endmodule

// ===== rtl/atup_cq.sv =====
// ----------------------------------------------------------------------------
// atup_cq: classified character queue
// Short FIFO between the classifier and the parse engine.
// ----------------------------------------------------------------------------
module atup_cq
    import atup_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  class_t push_data,
    output logic   full,
    input  logic   pop,
    output class_t pop_data,
    output logic   empty
);

    class_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/atup_back.sv =====
// ----------------------------------------------------------------------------
// atup_back: parse engine
// Runs the sign/prefix/digit sequence, accumulates digits with overflow
// detection and forms one result word at the first rejected character.
// ----------------------------------------------------------------------------
module atup_back
    import atup_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BASE_BITS-1:0] cfg_base,
    input  class_t               item,
    input  logic                 item_valid,
    output logic                 item_take,
    input  logic                 res_ready,
    output logic                 res_push,
    output result_t              res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE, ST_DIGITS, ST_OVF
    } status_t;

    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

    phase_t                 phase_reg, phase_next, ph;
    status_t                status_reg, status_next, st0, st_use;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next, acc0;
    logic                   minus_reg, minus_next, min0;
    logic [BASE_BITS-1:0]   base_reg, base_next, base0, base_use;
    logic [OFFSET_BITS-1:0] cnt_reg, cnt_next, cnt0;
    logic [PROD_BITS-1:0]   prod;
    logic                   step;
    logic                   go_digit;
    logic                   first;
    logic                   reject;
    logic                   emit;

    assign step      = item_valid && res_ready;
    assign item_take = step;

    always_comb
    begin
        // a start word clears the parse before the character is looked at
        ph    = item.start ? PH_SPACE : phase_reg;
        acc0  = item.start ? '0 : acc_reg;
        min0  = item.start ? 1'b0 : minus_reg;
        st0   = item.start ? ST_NONE : status_reg;
        base0 = item.start ? cfg_base : base_reg;
        cnt0  = item.start ? '0 : cnt_reg;

        phase_next  = ph;
        acc_next    = acc0;
        minus_next  = min0;
        status_next = st0;
        base_next   = base0;
        cnt_next    = cnt0;
        base_use    = base0;
        st_use      = st0;
        go_digit    = 1'b0;
        first       = 1'b0;
        emit        = 1'b0;

        unique case (ph)
            PH_SPACE:
            begin
                if (item.is_space)
                    phase_next = PH_SPACE;
                else if (item.is_sign)
                begin
                    minus_next = item.is_minus;
                    phase_next = PH_SIGNED;
                end
                else
                    first = 1'b1;
            end
            PH_SIGNED:
                first = 1'b1;
            PH_ZERO:
            begin
                if (item.is_x)
                begin
                    base_next  = BASE_HEX;
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    // the leading zero counts as a digit
                    base_use = (base0 == BASE_AUTO) ? BASE_OCT : base0;
                    st_use   = ST_DIGITS;
                    go_digit = 1'b1;
                end
            end
            PH_PREFIX, PH_DIGITS:
                go_digit = 1'b1;
            default:
                phase_next = ph;
        endcase

        if (first)
        begin
            if (((base0 == BASE_AUTO) || (base0 == BASE_HEX)) && item.is_zero)
                phase_next = PH_ZERO;
            else
            begin
                base_use = (base0 == BASE_AUTO) ? BASE_DEC : base0;
                go_digit = 1'b1;
            end
        end

        prod   = PROD_BITS'(acc0) * PROD_BITS'(base_use) + PROD_BITS'(item.digit);
        reject = (base_use == '0) || !item.digit_ok || (item.digit >= base_use);

        if (go_digit)
        begin
            base_next   = base_use;
            status_next = st_use;
            if (reject)
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_DIGITS;
                if ((st_use == ST_OVF) || (|prod[PROD_BITS-1:VALUE_BITS]))
                    status_next = ST_OVF;
                else
                begin
                    acc_next    = prod[VALUE_BITS-1:0];
                    status_next = ST_DIGITS;
                end
            end
        end

        if ((ph != PH_IDLE) && (ph != PH_DONE) && (cnt0 != '1))
            cnt_next = cnt0 + 1'b1;

        if (st_use == ST_OVF)
            res.value = '1;
        else if (min0)
            res.value = {VALUE_BITS{1'b0}} - acc0;
        else
            res.value = acc0;
        res.overflowed = (st_use == ST_OVF);
        res.parsed_any = (st_use != ST_NONE);
        res.end_offset = (st_use != ST_NONE) ? cnt0 : '0;
        res_push       = step && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            status_reg <= ST_NONE;
            acc_reg    <= '0;
            minus_reg  <= 1'b0;
            base_reg   <= '0;
            cnt_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            acc_reg    <= acc_next;
            minus_reg  <= minus_next;
            base_reg   <= base_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/atup_rq.sv =====
// ----------------------------------------------------------------------------
// atup_rq: result queue
// Short FIFO holding finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module atup_rq
    import atup_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output result_t pop_data,
    output logic    empty
);

    result_t                mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/ascii_to_unsigned_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_core: streaming ASCII to unsigned converter
// One character word per cycle in while neither queue is full, one result word
// per parsed string out. A result is written into the result queue at the edge
// that lets the parse engine take its rejected character, so it can be popped
// at the following edge at the earliest. Throughput: 1 character per cycle
// while neither queue is full, the multiply-accumulate (value * base + digit)
// in the parse engine being combinational. Reset: asynchronous, clears both
// queues, the parse state and the base register (automatic base).
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_core
    import atup_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   number_base_we,
    input  logic [BASE_BITS-1:0]   number_base,
    input  logic                   push,
    output logic                   full,
    input  logic [CHAR_BITS-1:0]   char_in,
    input  logic                   start_flag,
    output logic                   empty,
    input  logic                   pop,
    output logic [VALUE_BITS-1:0]  value,
    output logic                   overflowed,
    output logic                   parsed_any,
    output logic [OFFSET_BITS-1:0] end_offset
);

    logic [BASE_BITS-1:0] base_reg;
    class_t               cls_in;
    class_t               cls_out;
    logic                 cq_empty;
    logic                 back_take;
    logic                 rq_full;
    logic                 res_push;
    result_t              res_in;
    result_t              res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_AUTO;
        else if (number_base_we)
            base_reg <= number_base;
    end

    atup_front u_front (
        .char_in    (char_in),
        .start_flag (start_flag),
        .cls        (cls_in)
    );

    atup_cq u_cq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls_in),
        .full      (full),
        .pop       (back_take),
        .pop_data  (cls_out),
        .empty     (cq_empty)
    );

    atup_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_base   (base_reg),
        .item       (cls_out),
        .item_valid (!cq_empty),
        .item_take  (back_take),
        .res_ready  (!rq_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    atup_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (rq_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign value      = res_out.value;
    assign overflowed = res_out.overflowed;
    assign parsed_any = res_out.parsed_any;
    assign end_offset = res_out.end_offset;

    // engine must hold off while the result queue is full
    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rq_full |-> !back_take)
        else $error("parse engine stepped with result queue full");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overflowed) |-> (value == '1) && parsed_any)
        else $error("overflow result not saturated");

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !parsed_any) |-> (value == '0) && (end_offset == '0))
        else $error("empty parse result not zero");

endmodule

// ===== test/ascii_to_unsigned_parser_checker.sv =====
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_checker: result predictor and scoreboard
// Watches the base register writes, the character channel and the result
// channel of the parser core. Every accepted character goes through a local
// model of the string scanner. Every parsed string yields one expected
// result word, compared field by field with the next popped word.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_checker
    import atup_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   number_base_we,
    input  logic [BASE_BITS-1:0]   number_base,
    input  logic                   push,
    input  logic                   full,
    input  logic [CHAR_BITS-1:0]   char_in,
    input  logic                   start_flag,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [VALUE_BITS-1:0]  value,
    input  logic                   overflowed,
    input  logic                   parsed_any,
    input  logic [OFFSET_BITS-1:0] end_offset,
    output int unsigned            pending,
    output int unsigned            errors,
    output int unsigned            results_seen,
    output int unsigned            overflow_seen,
    output int unsigned            no_digit_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BLANKS, ST_SIGN, ST_LEAD_ZERO, ST_PREFIX, ST_DIGITS, ST_DONE
    } scan_state_e;

    typedef enum logic [1:0] {DS_NONE, DS_DIGITS, DS_OVERFLOW} digit_state_e;

    localparam logic [VALUE_BITS-1:0]  ALL_ONES    = '1;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [6:0]             NOT_A_DIGIT = 7'd99;

    logic [BASE_BITS-1:0]   base_shadow;
    logic [BASE_BITS-1:0]   cur_base;
    scan_state_e            scan;
    digit_state_e           dstat;
    logic [VALUE_BITS-1:0]  acc;
    logic                   neg;
    logic [OFFSET_BITS-1:0] char_cnt;
    result_t                expected_q[$];
    int unsigned            n_err, n_res, n_ovf, n_blank;

    task automatic report(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        n_err++;
    endtask

    function automatic logic [6:0] digit_of(input logic [CHAR_BITS-1:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 7'(c - CH_0);
        if (c >= CH_UA && c <= CH_UZ)
            return 7'(c - CH_UPPER_OFS);
        if (c >= CH_LA && c <= CH_LZ)
            return 7'(c - CH_LOWER_OFS);
        return NOT_A_DIGIT;
    endfunction

    task automatic finish_string();
        result_t r;
        r.overflowed = (dstat == DS_OVERFLOW);
        r.parsed_any = (dstat != DS_NONE);
        if (dstat == DS_OVERFLOW)
            r.value = ALL_ONES;
        else if (neg)
            r.value = ~acc + 1'b1;
        else
            r.value = acc;
        r.end_offset = r.parsed_any ? char_cnt : '0;
        expected_q.push_back(r);
        scan = ST_DONE;
    endtask

    task automatic accumulate(input logic [6:0] d);
        logic [VALUE_BITS-1:0] b;
        logic [VALUE_BITS-1:0] cut;
        logic [VALUE_BITS-1:0] lim;
        b   = VALUE_BITS'(cur_base);
        cut = ALL_ONES / b;
        lim = ALL_ONES % b;
        // once saturated, later digits are eaten but change nothing
        if (dstat == DS_OVERFLOW || acc > cut || (acc == cut && VALUE_BITS'(d) > lim)) begin
            dstat = DS_OVERFLOW;
        end else begin
            acc   = acc * b + VALUE_BITS'(d);
            dstat = DS_DIGITS;
        end
    endtask

    task automatic digit_step(input logic [CHAR_BITS-1:0] c);
        logic [6:0] d;
        d = digit_of(c);
        if (cur_base == BASE_AUTO || d >= 7'(cur_base))
            finish_string();
        else
            accumulate(d);
    endtask

    task automatic first_digit(input logic [CHAR_BITS-1:0] c);
        if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && c == CH_0) begin
            scan = ST_LEAD_ZERO;
        end else begin
            if (cur_base == BASE_AUTO)
                cur_base = BASE_DEC;
            scan = ST_DIGITS;
            digit_step(c);
        end
    endtask

    task automatic parse_char(input logic [CHAR_BITS-1:0] c, input logic s);
        if (s) begin
            scan     = ST_BLANKS;
            acc      = '0;
            neg      = 1'b0;
            dstat    = DS_NONE;
            cur_base = base_shadow;
            char_cnt = '0;
        end
        case (scan)
            ST_BLANKS: begin
                if (c == CH_SPACE || c == CH_NL || c == CH_CR || c == CH_TAB) begin
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    neg  = (c == CH_MINUS);
                    scan = ST_SIGN;
                end else begin
                    first_digit(c);
                end
            end
            ST_SIGN: first_digit(c);
            ST_LEAD_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    cur_base = BASE_HEX;
                    scan     = ST_PREFIX;
                end else begin
                    if (cur_base == BASE_AUTO)
                        cur_base = BASE_OCT;
                    accumulate(7'd0);
                    scan = ST_DIGITS;
                    digit_step(c);
                end
            end
            ST_PREFIX: begin
                scan = ST_DIGITS;
                digit_step(c);
            end
            ST_DIGITS: digit_step(c);
            default: return;  // idle or done: word ignored, count frozen
        endcase
        if (char_cnt != COUNT_MAX)
            char_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            base_shadow = BASE_AUTO;
            cur_base    = BASE_AUTO;
            scan        = ST_IDLE;
            dstat       = DS_NONE;
            acc         = '0;
            neg         = 1'b0;
            char_cnt    = '0;
            expected_q.delete();
            n_err       = 0;
            n_res       = 0;
            n_ovf       = 0;
            n_blank     = 0;
        end else begin
            if (number_base_we)
                base_shadow = number_base;
            if (push && !full)
                parse_char(char_in, start_flag);
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    report($sformatf("result word with none expected: value %0h", value));
                end else begin
                    want = expected_q.pop_front();
                    n_res++;
                    if (want.overflowed)
                        n_ovf++;
                    if (!want.parsed_any)
                        n_blank++;
                    if (value !== want.value)
                        report($sformatf("value %0h, expected %0h", value, want.value));
                    if (overflowed !== want.overflowed)
                        report($sformatf("overflowed %b, expected %b",
                                         overflowed, want.overflowed));
                    if (parsed_any !== want.parsed_any)
                        report($sformatf("parsed_any %b, expected %b",
                                         parsed_any, want.parsed_any));
                    if (end_offset !== want.end_offset)
                        report($sformatf("end_offset %0d, expected %0d",
                                         end_offset, want.end_offset));
                end
            end
        end
        pending       <= expected_q.size();
        errors        <= n_err;
        results_seen  <= n_res;
        overflow_seen <= n_ovf;
        no_digit_seen <= n_blank;
    end

endmodule

// ===== test/ascii_to_unsigned_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_core_tb: stimulus and verdict for the parser core
// Short directed strings for blanks, signs, prefixes and restarts, then
// random strings (mostly well formed, some broken, some noise) over a sweep
// of base settings and four idle/stall mixes. The checker beside the core
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import atup_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PHASE_CHARS  = 240;

    localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   number_base_we = 1'b0;
    logic [BASE_BITS-1:0]   number_base    = BASE_AUTO;
    logic                   push           = 1'b0;
    logic                   full;
    logic [CHAR_BITS-1:0]   char_in        = '0;
    logic                   start_flag     = 1'b0;
    logic                   empty;
    logic                   pop            = 1'b0;
    logic [VALUE_BITS-1:0]  value;
    logic                   overflowed;
    logic                   parsed_any;
    logic [OFFSET_BITS-1:0] end_offset;

    int unsigned pending, errors, results_seen, overflow_seen, no_digit_seen;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned n_chars   = 0;
    int unsigned n_strings = 0;
    int unsigned n_bases   = 0;
    int unsigned cycles    = 0;

    logic [CHAR_BITS-1:0] str_q[$];

    ascii_to_unsigned_parser_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .number_base_we (number_base_we),
        .number_base    (number_base),
        .push           (push),
        .full           (full),
        .char_in        (char_in),
        .start_flag     (start_flag),
        .empty          (empty),
        .pop            (pop),
        .value          (value),
        .overflowed     (overflowed),
        .parsed_any     (parsed_any),
        .end_offset     (end_offset)
    );

    ascii_to_unsigned_parser_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .number_base_we (number_base_we),
        .number_base    (number_base),
        .push           (push),
        .full           (full),
        .char_in        (char_in),
        .start_flag     (start_flag),
        .empty          (empty),
        .pop            (pop),
        .value          (value),
        .overflowed     (overflowed),
        .parsed_any     (parsed_any),
        .end_offset     (end_offset),
        .pending        (pending),
        .errors         (errors),
        .results_seen   (results_seen),
        .overflow_seen  (overflow_seen),
        .no_digit_seen  (no_digit_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // one character word, held until the core takes it
    task automatic put_char(input logic [CHAR_BITS-1:0] c, input logic s);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        char_in    <= c;
        start_flag <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n_chars++;
    endtask

    task automatic send_string();
        foreach (str_q[i])
            put_char(str_q[i], i == 0);
        n_strings++;
    endtask

    task automatic send_text(input string s, input logic [CHAR_BITS-1:0] term);
        str_q.delete();
        for (int i = 0; i < s.len(); i++)
            str_q.push_back(s[i]);
        str_q.push_back(term);
        send_string();
    endtask

    // sender holds off until every result word has been popped
    task automatic quiesce();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_base(input logic [BASE_BITS-1:0] b);
        quiesce();
        number_base_we <= 1'b1;
        number_base    <= b;
        @(posedge clk);
        number_base_we <= 1'b0;
        n_bases++;
    endtask

    function automatic logic [CHAR_BITS-1:0] digit_char(input int d);
        if (d < 10)
            return CH_0 + CHAR_BITS'(d);
        return ($urandom_range(1) ? CH_UA : CH_LA) + CHAR_BITS'(d - 10);
    endfunction

    function automatic logic [CHAR_BITS-1:0] blank_char();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_digits(input int b, input int n);
        repeat (n)
            str_q.push_back(digit_char((b < 2) ? 0 : $urandom_range(b - 1)));
    endtask

    // 2^64-1 written in base b; with over set, one step past it, or b times it when its last digit is b-1
    task automatic add_limit(input int b, input bit over);
        logic [VALUE_BITS-1:0] v;
        logic [CHAR_BITS-1:0]  tmp[$];
        int                    low;
        v = ALL_ONES;
        while (v != 0) begin
            tmp.push_front(digit_char(int'(v % b)));
            v = v / b;
        end
        low = int'(ALL_ONES % b);
        if (over) begin
            if (low < b - 1)
                tmp[$] = digit_char(low + 1);
            else
                tmp.push_back(CH_0);
        end
        foreach (tmp[i])
            str_q.push_back(tmp[i]);
    endtask

    task automatic build_random(input logic [BASE_BITS-1:0] base);
        int roll, b, n;
        str_q.delete();
        roll = $urandom_range(99);
        if (roll < 70) begin
            repeat ($urandom_range(2))
                str_q.push_back(blank_char());
            if ($urandom_range(99) < 30)
                str_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            b = int'(base);
            if (base == BASE_AUTO) begin
                n = $urandom_range(99);
                if (n < 40) begin
                    b = 10;
                end else if (n < 65) begin
                    str_q.push_back(CH_0);
                    b = 8;
                end else begin
                    str_q.push_back(CH_0);
                    str_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    b = 16;
                end
            end else if (base == BASE_HEX && $urandom_range(99) < 40) begin
                str_q.push_back(CH_0);
                str_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
            end
            if (b >= 2 && b <= 36 && $urandom_range(99) < 10) begin
                add_limit(b, $urandom_range(1));
            end else begin
                n = $urandom_range(99);
                if (n < 60)
                    n = $urandom_range(1, 6);
                else if (n < 90)
                    n = $urandom_range(7, 24);
                else
                    n = $urandom_range(25, 70);
                add_digits((b > 36) ? 36 : b, n);
            end
            case ($urandom_range(3))
                0, 1: str_q.push_back(8'h00);
                2: str_q.push_back(blank_char());
                default: str_q.push_back(CHAR_BITS'($urandom_range(255)));
            endcase
        end else if (roll < 85) begin
            case ($urandom_range(3))
                0: begin  // doubled sign
                    str_q.push_back(CH_PLUS);
                    str_q.push_back(CH_MINUS);
                    add_digits(10, 2);
                end
                1: begin  // blank after the sign
                    str_q.push_back(CH_MINUS);
                    str_q.push_back(blank_char());
                    add_digits(10, 2);
                end
                2: begin  // hex prefix with no hex digit
                    str_q.push_back(CH_0);
                    str_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    str_q.push_back(CHAR_BITS'($urandom_range(8'h67, 8'h7A)));
                end
                default: begin  // cut short, abandoned by the next start
                    str_q.push_back(blank_char());
                    add_digits(8, $urandom_range(1, 5));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 6))
                str_q.push_back(CHAR_BITS'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic [BASE_BITS-1:0] sweep[8];
        int unsigned          phase_chars;
        int unsigned          sweep_idx;
        logic [BASE_BITS-1:0] base;
        sweep = '{6'd1, 6'd36, 6'd63, 6'd2, BASE_HEX, BASE_OCT, BASE_DEC, BASE_AUTO};
        sweep_idx = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings, automatic base
        set_base(BASE_AUTO);
        send_text(" \t\n\015-12", 8'h00);
        send_text("017", 8'hFF);
        send_text("0XaF", 8'h00);
        send_text("0x", "g");
        send_text("+", CH_SPACE);
        send_text("-+5", 8'h00);
        put_char("9", 1'b1);          // abandoned by the restart below
        send_text("5", 8'h00);
        put_char("3", 1'b0);          // after done: ignored

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) begin
                if (sweep_idx < 8) begin
                    base = sweep[sweep_idx];
                end else if ($urandom_range(1)) begin
                    case ($urandom_range(3))
                        0: base = BASE_AUTO;
                        1: base = BASE_DEC;
                        2: base = BASE_HEX;
                        default: base = BASE_OCT;
                    endcase
                end else begin
                    base = BASE_BITS'($urandom_range(63));
                end
                sweep_idx++;
                set_base(base);
                repeat ($urandom_range(4, 8)) begin
                    build_random(base);
                    phase_chars += str_q.size();
                    send_string();
                    if ($urandom_range(99) < 10)
                        repeat ($urandom_range(1, 3))
                            put_char(CHAR_BITS'($urandom_range(255)), 1'b0);
                end
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d characters in %0d strings under %0d base settings, four idle/stall mixes",
                 n_chars, n_strings, n_bases);
        $display("%0d result words checked: %0d saturated on overflow, %0d with no digits",
                 results_seen, overflow_seen, no_digit_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
